### src/two_point_linear_interpolator_defines.svh
// Assertion macros for the checker file.
// Each macro expects clk and arst_n in scope.
`ifndef TWO_POINT_LINEAR_INTERPOLATOR_DEFINES_SVH
`define TWO_POINT_LINEAR_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TPLI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpli assertion failed");

// Next-cycle implication, disabled during reset.
`define TPLI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpli assertion failed");

`endif

### src/tpli_pkg.sv
// ----------------------------------------------------------------------------
// tpli_pkg
// Shared constants, status codes and side-band control for the interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpli_pkg;

	localparam int FIELD_BITS     = 32;
	localparam int VALUE_BITS_DEF = 32;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NULL  = 2'd1,
		ST_RANGE = 2'd2
	} tpli_status_t;

	// side-band that rides along every stage with the arithmetic payload
	typedef struct packed {
		logic         neg;    // sign of the quotient term
		logic         fixed;  // result is fixed, arithmetic is ignored
		tpli_status_t fstat;  // status used when fixed is set
	} tpli_ctl_t;

endpackage

### src/tpli_front.sv
// ----------------------------------------------------------------------------
// tpli_front
// Differences, magnitudes, product and quotient overflow check (three stages).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpli_front #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  logic [W-1:0]        qx,
	input  logic [W-1:0]        x0,
	input  logic [W-1:0]        y0,
	input  logic [W-1:0]        x1,
	input  logic [W-1:0]        y1,
	output logic                v_s3,
	output logic [W-1:0]        rem_s3,
	output logic [W-1:0]        sh_s3,
	output logic [W-1:0]        den_s3,
	output logic [W-1:0]        y0_s3,
	output tpli_pkg::tpli_ctl_t ctl_s3
);
	import tpli_pkg::*;

	logic signed [W:0] dx, dy, dn;
	logic [W-1:0]      mdx, mdy, mdn;
	tpli_ctl_t         ctl_c1;

	logic              v_s1, v_s2;
	logic [W-1:0]      mdx_s1, mdy_s1, mdn_s1, y0_s1;
	tpli_ctl_t         ctl_s1;
	logic [2*W-1:0]    prod;
	logic [2*W-1:0]    mnum_s2;
	logic [W-1:0]      mdn_s2, y0_s2;
	tpli_ctl_t         ctl_s2;
	logic              ovf;
	tpli_ctl_t         ctl_c3;

	// stage 1: differences in W+1 bits, magnitudes fit in W bits
	assign dx  = $signed({qx[W-1], qx}) - $signed({x0[W-1], x0});
	assign dy  = $signed({y1[W-1], y1}) - $signed({y0[W-1], y0});
	assign dn  = $signed({x1[W-1], x1}) - $signed({x0[W-1], x0});
	assign mdx = dx[W] ? W'(-dx) : dx[W-1:0];
	assign mdy = dy[W] ? W'(-dy) : dy[W-1:0];
	assign mdn = dn[W] ? W'(-dn) : dn[W-1:0];

	always_comb begin
		ctl_c1.neg   = dx[W] ^ dy[W] ^ dn[W];
		ctl_c1.fixed = (x0 == x1);
		ctl_c1.fstat = ((qx == x0) && (y0 == y1)) ? ST_OK : ST_NULL;
	end

	// stage 2: magnitude product
	assign prod = mdx_s1 * mdy_s1;

	// stage 3: a quotient that does not fit in W bits is always out of range
	assign ovf = (mnum_s2[2*W-1:W] >= mdn_s2);

	always_comb begin
		ctl_c3 = ctl_s2;
		if (!ctl_s2.fixed && ovf) begin
			ctl_c3.fixed = 1'b1;
			ctl_c3.fstat = ST_RANGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mdx_s1  <= mdx;
			mdy_s1  <= mdy;
			mdn_s1  <= mdn;
			y0_s1   <= y0;
			ctl_s1  <= ctl_c1;
			mnum_s2 <= prod;
			mdn_s2  <= mdn_s1;
			y0_s2   <= y0_s1;
			ctl_s2  <= ctl_s1;
			rem_s3  <= mnum_s2[2*W-1:W];
			sh_s3   <= mnum_s2[W-1:0];
			den_s3  <= mdn_s2;
			y0_s3   <= y0_s2;
			ctl_s3  <= ctl_c3;
		end
	end

endmodule

### src/tpli_div_step.sv
// ----------------------------------------------------------------------------
// tpli_div_step
// One restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpli_div_step #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                v_i,
	input  logic [W-1:0]        rem_i,
	input  logic [W-1:0]        sh_i,
	input  logic [W-1:0]        den_i,
	input  logic [W-1:0]        y0_i,
	input  tpli_pkg::tpli_ctl_t ctl_i,
	output logic                v_o,
	output logic [W-1:0]        rem_o,
	output logic [W-1:0]        sh_o,
	output logic [W-1:0]        den_o,
	output logic [W-1:0]        y0_o,
	output tpli_pkg::tpli_ctl_t ctl_o
);
	import tpli_pkg::*;

	logic [W:0] trial, diff;
	logic       ge;

	// shift the next dividend bit in, subtract the divisor if it fits
	assign trial = {rem_i, sh_i[W-1]};
	assign diff  = trial - {1'b0, den_i};
	assign ge    = (trial >= {1'b0, den_i});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (adv) begin
			v_o <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_o <= ge ? diff[W-1:0] : trial[W-1:0];
			sh_o  <= {sh_i[W-2:0], ge};
			den_o <= den_i;
			y0_o  <= y0_i;
			ctl_o <= ctl_i;
		end
	end

endmodule

### src/tpli_back.sv
// ----------------------------------------------------------------------------
// tpli_back
// Accumulate, round half away from zero, range check, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpli_back #(
	parameter int W = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         v_i,
	input  logic [W-1:0]                 quo,
	input  logic [W-1:0]                 rem,
	input  logic [W-1:0]                 den,
	input  logic [W-1:0]                 y0_i,
	input  tpli_pkg::tpli_ctl_t          ctl_i,
	output logic                         v_o,
	output logic [tpli_pkg::FIELD_BITS-1:0] value_o,
	output tpli_pkg::tpli_status_t       status_o
);
	import tpli_pkg::*;

	logic signed [W+1:0] acc, res;
	logic [W:0]          twice;
	logic                ge, gt, bump;

	logic                v_s1, v_s2;
	logic signed [W+1:0] acc_s1, res_s2;
	logic                bump_s1;
	logic [W-1:0]        y0_s1, y0_s2;
	tpli_ctl_t           ctl_s1, ctl_s2;

	logic                in_rng;
	logic signed [W-1:0] fin;
	tpli_status_t        st;

	// stage 1: y0 +/- quotient, and the rounding decision from the remainder
	assign acc   = ctl_i.neg ? $signed({{2{y0_i[W-1]}}, y0_i}) - $signed({2'b00, quo})
	                         : $signed({{2{y0_i[W-1]}}, y0_i}) + $signed({2'b00, quo});
	assign twice = {rem, 1'b0};
	assign ge    = (twice >= {1'b0, den});
	assign gt    = (twice > {1'b0, den});

	// exact halves go away from zero, judged on the sign of the whole value
	always_comb begin
		if (ctl_i.neg) begin
			bump = (acc <= 0) ? ge : gt;
		end else begin
			bump = (acc >= 0) ? ge : gt;
		end
	end

	// stage 2: apply the rounding step
	assign res = bump_s1 ? (ctl_s1.neg ? acc_s1 - (W+2)'(1) : acc_s1 + (W+2)'(1)) : acc_s1;

	// stage 3: range check and final selection
	assign in_rng = (res_s2[W+1] == res_s2[W]) && (res_s2[W] == res_s2[W-1]);

	always_comb begin
		if (ctl_s2.fixed) begin
			st  = ctl_s2.fstat;
			fin = (ctl_s2.fstat == ST_OK) ? $signed(y0_s2) : '0;
		end else if (in_rng) begin
			st  = ST_OK;
			fin = res_s2[W-1:0];
		end else begin
			st  = ST_RANGE;
			fin = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_o  <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
			v_o  <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s1   <= acc;
			bump_s1  <= bump;
			y0_s1    <= y0_i;
			ctl_s1   <= ctl_i;
			res_s2   <= res;
			y0_s2    <= y0_s1;
			ctl_s2   <= ctl_s1;
			value_o  <= FIELD_BITS'(fin);
			status_o <= st;
		end
	end

endmodule

### src/two_point_linear_interpolator.sv
// ----------------------------------------------------------------------------
// two_point_linear_interpolator: VALUE_BITS + 6 register stages.
// Throughput one beat per cycle while the output is not stalled; the divider
// chain computes one quotient bit per stage.
// Reset clears only the stage valid bits; no clearing pass, ready right away.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_point_linear_interpolator #(
	parameter int VALUE_BITS = tpli_pkg::VALUE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [tpli_pkg::FIELD_BITS-1:0] query_x,
	input  logic signed [tpli_pkg::FIELD_BITS-1:0] left_x,
	input  logic signed [tpli_pkg::FIELD_BITS-1:0] left_y,
	input  logic signed [tpli_pkg::FIELD_BITS-1:0] right_x,
	input  logic signed [tpli_pkg::FIELD_BITS-1:0] right_y,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [tpli_pkg::FIELD_BITS-1:0] interp_value,
	output logic [1:0]                         status
);
	import tpli_pkg::*;

	localparam int W = VALUE_BITS;

	// Pipeline overview:
	//   front : s1 differences/magnitudes, s2 product, s3 overflow check
	//   div   : W restoring steps, one quotient bit each
	//   back  : accumulate + round decision, round step, range check/output
	// The whole pipeline moves as one: advance whenever the output register
	// is empty or its beat is being taken. Nothing is dropped or repeated.

	logic                adv;
	logic [W-1:0]        rem_c [0:W];
	logic [W-1:0]        sh_c  [0:W];
	logic [W-1:0]        den_c [0:W];
	logic [W-1:0]        y0_c  [0:W];
	tpli_ctl_t           ctl_c [0:W];
	logic                v_c   [0:W];
	tpli_status_t        st_o;

	// hold everything while the output beat is stalled
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	tpli_front #(.W(W)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.qx       (query_x[W-1:0]),
		.x0       (left_x[W-1:0]),
		.y0       (left_y[W-1:0]),
		.x1       (right_x[W-1:0]),
		.y1       (right_y[W-1:0]),
		.v_s3     (v_c[0]),
		.rem_s3   (rem_c[0]),
		.sh_s3    (sh_c[0]),
		.den_s3   (den_c[0]),
		.y0_s3    (y0_c[0]),
		.ctl_s3   (ctl_c[0])
	);

	// divider chain: after W steps sh holds the quotient, rem the remainder
	for (genvar k = 0; k < W; k++) begin : g_div
		tpli_div_step #(.W(W)) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.v_i    (v_c[k]),
			.rem_i  (rem_c[k]),
			.sh_i   (sh_c[k]),
			.den_i  (den_c[k]),
			.y0_i   (y0_c[k]),
			.ctl_i  (ctl_c[k]),
			.v_o    (v_c[k+1]),
			.rem_o  (rem_c[k+1]),
			.sh_o   (sh_c[k+1]),
			.den_o  (den_c[k+1]),
			.y0_o   (y0_c[k+1]),
			.ctl_o  (ctl_c[k+1])
		);
	end

	tpli_back #(.W(W)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.v_i      (v_c[W]),
		.quo      (sh_c[W]),
		.rem      (rem_c[W]),
		.den      (den_c[W]),
		.y0_i     (y0_c[W]),
		.ctl_i    (ctl_c[W]),
		.v_o      (out_valid),
		.value_o  (interp_value),
		.status_o (st_o)
	);

	assign status = st_o;

endmodule

### src/tpli_checker.sv
// ----------------------------------------------------------------------------
// tpli_checker
// Port-level checks on the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_point_linear_interpolator_defines.svh"

module tpli_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [tpli_pkg::FIELD_BITS-1:0]    interp_value,
	input logic [1:0]                         status
);
	import tpli_pkg::*;

	// a stalled result beat holds
	`TPLI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(interp_value) && $stable(status))
	// input side is open exactly when the output register can move
	`TPLI_ASSERT_NOW(a_ready_link, 1'b1, in_ready == (!out_valid || out_ready))
	// a failed result carries a zero value
	`TPLI_ASSERT_NOW(a_zero_on_fail, out_valid && (status != ST_OK), interp_value == '0)
	// only the three defined status codes appear
	`TPLI_ASSERT_NOW(a_status_code, out_valid, (status == ST_OK) || (status == ST_NULL) || (status == ST_RANGE))

endmodule

bind two_point_linear_interpolator tpli_checker u_tpli_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.interp_value (interp_value),
	.status       (status)
);

### bench/two_point_linear_interpolator_test.sv
// ----------------------------------------------------------------------------
// two_point_linear_interpolator_test
// Drives random and corner-case interpolation beats through the block under
// varying input and output stalls, and checks every result against an exact
// rational predictor written here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_point_linear_interpolator_test;

	import tpli_pkg::*;

	localparam int NUM_RANDOM = 1550;
	localparam int LATENCY    = 38;

	typedef struct packed {
		logic [31:0] qx;
		logic [31:0] x0;
		logic [31:0] y0;
		logic [31:0] x1;
		logic [31:0] y1;
	} point_set_t;

	typedef struct packed {
		logic [31:0]  value;
		tpli_status_t stat;
	} interp_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] query_x, left_x, left_y, right_x, right_y;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] interp_value;
	logic [1:0]  status;

	point_set_t     pending_sets[$];
	interp_result_t expected_results[$];
	int             phase;       // 0: receiver idles more, 1: sender idles more, 2: no idling
	int             hold_off;    // cycles left in a long receiver stall
	bit             failed;
	bit             stim_done;

	two_point_linear_interpolator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.query_x(query_x), .left_x(left_x), .left_y(left_y),
		.right_x(right_x), .right_y(right_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.interp_value(interp_value), .status(status)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Exact interpolation: integer quotient plus remainder, round half away
	// from zero on the sign of the whole value.
	function automatic interp_result_t interpolate(point_set_t p);
		longint qx, x0, y0, x1, y1, dx, dy, den, acc, res;
		longint unsigned mnum, mden, quo, rem;
		bit neg;
		interp_result_t r;
		qx = longint'(signed'(p.qx));
		x0 = longint'(signed'(p.x0));
		y0 = longint'(signed'(p.y0));
		x1 = longint'(signed'(p.x1));
		y1 = longint'(signed'(p.y1));
		r.value = '0;
		r.stat  = ST_OK;
		if (x0 == x1) begin
			if (qx == x0 && y0 == y1)
				r.value = p.y0;
			else
				r.stat = ST_NULL;
			return r;
		end
		dx = qx - x0;
		dy = y1 - y0;
		den = x1 - x0;
		neg = ((dx < 0) != (dy < 0)) != (den < 0);
		mnum = (dx < 0 ? -dx : dx) * (dy < 0 ? -dy : dy);
		mden = den < 0 ? -den : den;
		quo = mnum / mden;
		rem = mnum % mden;
		if (quo >= 64'h4_0000_0000) begin
			r.stat = ST_RANGE;
			return r;
		end
		acc = neg ? y0 - longint'(quo) : y0 + longint'(quo);
		res = acc;
		if (rem != 0) begin
			if (!neg) begin
				if ((acc >= 0 && rem * 2 >= mden) || (acc < 0 && rem * 2 > mden))
					res = acc + 1;
			end else begin
				if ((acc <= 0 && rem * 2 >= mden) || (acc > 0 && rem * 2 > mden))
					res = acc - 1;
			end
		end
		if (res < -64'sd2147483648 || res > 64'sd2147483647)
			r.stat = ST_RANGE;
		else
			r.value = res[31:0];
		return r;
	endfunction

	function automatic logic [31:0] corner_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'hffff_ffff;
			4: return 32'($urandom_range(0, 20)) - 32'd10;
			5: return $urandom;
			default: return 32'($urandom_range(0, 2000)) - 32'd1000;
		endcase
	endfunction

	task automatic add_set(logic [31:0] qx, x0, y0, x1, y1);
		pending_sets.push_back('{qx: qx, x0: x0, y0: y0, x1: x1, y1: y1});
	endtask

	// Fill the stimulus queue: directed corners first, then random sets.
	initial begin
		logic [31:0] a, b;
		// degenerate interval: valid single point, mismatched y, mismatched x
		add_set(32'd5, 32'd5, 32'd9, 32'd5, 32'd9);
		add_set(32'd5, 32'd5, 32'd9, 32'd5, 32'd8);
		add_set(32'd6, 32'd5, 32'd9, 32'd5, 32'd9);
		add_set(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff);
		// exact halves, positive and negative, both fraction signs; then thirds
		add_set(32'd1, 32'd0, 32'd0, 32'd2, 32'd1);
		add_set(32'd1, 32'd0, 32'd0, 32'd2, -32'd1);
		add_set(32'd1, 32'd0, 32'd5, 32'd2, 32'd4);
		add_set(32'd1, 32'd0, -32'd5, 32'd2, -32'd4);
		add_set(32'd1, 32'd0, 32'd0, 32'd3, 32'd1);
		add_set(32'd2, 32'd0, 32'd0, 32'd3, 32'd1);
		// extrapolation, reversed interval
		add_set(32'd10, 32'd0, 32'd0, 32'd1, 32'd3);
		add_set(-32'd10, 32'd4, 32'd1, 32'd2, 32'd7);
		// extremes: huge quotient, edge of range, out of range
		add_set(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 32'h7fff_ffff);
		add_set(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		add_set(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
		add_set(32'd2, 32'd0, 32'h7fff_fffe, 32'd1, 32'h7fff_ffff);
		add_set(32'd2, 32'd0, 32'h8000_0001, 32'd1, 32'h8000_0000);
		add_set(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		add_set(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		for (int i = 0; i < NUM_RANDOM; i++) begin
			case ($urandom_range(0, 9))
				0: add_set($urandom, $urandom, $urandom, $urandom, $urandom);
				1: begin
					a = corner_value();
					b = corner_value();
					add_set($urandom_range(0, 1) ? a : corner_value(), a, b,
						a, $urandom_range(0, 1) ? b : corner_value());
				end
				2, 3: add_set(corner_value(), corner_value(), corner_value(),
					corner_value(), corner_value());
				default: begin
					// query inside or near the interval, moderate spans
					a = corner_value();
					b = a + 32'($urandom_range(1, 1 << $urandom_range(1, 30)));
					add_set(a + 32'($urandom_range(0, 64)) + (b - a) / 2 - 32'd32,
						a, corner_value(), b, $urandom);
				end
			endcase
		end
		stim_done = 1'b1;
	end

	initial begin
		failed = 1'b0;
		phase = 0;
		hold_off = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: offer the next set; hold it until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			{query_x, left_x, left_y, right_x, right_y} <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				expected_results.push_back(interpolate({query_x, left_x, left_y,
					right_x, right_y}));
			if (pending_sets.size() > 0 &&
			    !(phase == 0 && $urandom_range(0, 99) < 32) &&
			    !(phase == 1 && $urandom_range(0, 99) < 58)) begin
				point_set_t p;
				p = pending_sets.pop_front();
				in_valid <= 1'b1;
				{query_x, left_x, left_y, right_x, right_y} <= p;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Phase and long stall control, driven off the remaining queue depth.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pending_sets.size() < 1000 && phase == 0) begin
				phase <= 1;
				hold_off <= 300;
			end else if (pending_sets.size() < 500 && phase == 1)
				phase <= 2;
			else if (hold_off > 0)
				hold_off <= hold_off - 1;
		end
	end

	// Monitor: check each accepted result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result value=%h status=%0d",
						$time, interp_value, status);
					failed = 1'b1;
				end else begin
					interp_result_t e;
					e = expected_results.pop_front();
					if (e.value !== interp_value || e.stat !== status) begin
						$display("%0t: mismatch expected value=%h status=%0d actual value=%h status=%0d",
							$time, e.value, e.stat, interp_value, status);
						failed = 1'b1;
					end
				end
			end
			if (hold_off > 0)
				out_ready <= 1'b0;
			else if (phase == 0)
				out_ready <= $urandom_range(0, 99) >= 58;
			else if (phase == 1)
				out_ready <= $urandom_range(0, 99) >= 32;
			else
				out_ready <= 1'b1;
		end
	end

	// End of run: drain everything, then allow the pipeline to settle.
	initial begin
		wait (stim_done);
		@(posedge clk);
		while (pending_sets.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (!failed && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

endmodule
